@@ src/spti_pkg.sv @@
// Shared types and constants of the sync-point time interpolator.
package spti_pkg;

  localparam int unsigned TW = 44;

  localparam logic [TW-1:0] EPOCH_MS = 44'd315964800000;
  localparam logic [29:0]   WEEK_MS  = 30'd604800000;
  localparam logic [TW-1:0] GUARD_MS = 44'd3600000;
  localparam logic [TW-1:0] MASK44   = {TW{1'b1}};
  localparam logic [46:0]   QCAP     = 47'd1 << 46;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] CONF_EXACT    = 3'd0;
  localparam logic [2:0] CONF_INTERP   = 3'd1;
  localparam logic [2:0] CONF_FORWARD  = 3'd2;
  localparam logic [2:0] CONF_BACKWARD = 3'd3;
  localparam logic [2:0] CONF_SESSION  = 3'd4;

  localparam logic [2:0] CFG_ANCHOR_WEEK  = 3'd0;
  localparam logic [2:0] CFG_WIN_START    = 3'd1;
  localparam logic [2:0] CFG_WIN_END      = 3'd2;
  localparam logic [2:0] CFG_UP_OFFSET    = 3'd3;
  localparam logic [2:0] CFG_UP_OFF_VALID = 3'd4;
  localparam logic [2:0] CFG_FIRST_UP     = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PRE, ST_CHK, ST_FP, ST_GRD, ST_BS, ST_BSW, ST_EXR, ST_EXW,
    ST_RDP, ST_RDQ, ST_QW, ST_DIFF, ST_MUL, ST_DIV, ST_OFF, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    RD_ZERO, RD_MID, RD_LO, RD_P, RD_Q
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    cap;
    logic    pre;
    logic    bridge;
    logic    raw;
    logic    fp;
    logic    bs_init;
    logic    bs_step;
    logic    exact;
    logic    pick;
    logic    p_cap;
    logic    q_cap;
    logic    diff;
    logic    mul;
    logic    div;
    logic    off;
    logic    fin;
    logic    rd_en;
    rd_sel_e rd_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ge_epoch;
    logic n_zero;
    logic bridge;
    logic fp;
    logic guard;
    logic bs_more;
    logic exact;
    logic slope;
    logic last_mul;
    logic last_div;
  } stat_t;

  // Clamps a signed time-of-week to the 44-bit range.
  function automatic logic [TW-1:0] clamp_tow(input logic signed [47:0] v);
    logic [TW-1:0] r;
    if (v[47]) begin
      r = '0;
    end else if (v[46:44] != 3'd0) begin
      r = MASK44;
    end else begin
      r = v[43:0];
    end
    return r;
  endfunction

endpackage

@@ src/spti_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module spti_ram #(
  parameter int unsigned WIDTH = 88,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/spti_ctrl.sv @@
// Controller state machine of the sync-point time interpolator.
module spti_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           func_i,
  input  spti_pkg::stat_t stat_i,
  output spti_pkg::cmd_t  cmd_o,
  output logic           busy
);
  import spti_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start && func_i == FUNC_QUERY) state_d = ST_PRE;
      ST_PRE:  state_d = ST_CHK;
      ST_CHK: begin
        if (stat_i.ge_epoch || stat_i.n_zero || stat_i.bridge) state_d = ST_FIN;
        else state_d = ST_FP;
      end
      ST_FP:   state_d = stat_i.fp ? ST_FIN : ST_GRD;
      ST_GRD:  state_d = stat_i.guard ? ST_FIN : ST_BS;
      ST_BS:   state_d = stat_i.bs_more ? ST_BSW : ST_EXR;
      ST_BSW:  state_d = ST_BS;
      ST_EXR:  state_d = ST_EXW;
      ST_EXW:  state_d = stat_i.exact ? ST_FIN : ST_RDP;
      ST_RDP:  state_d = ST_RDQ;
      ST_RDQ:  state_d = ST_QW;
      ST_QW:   state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL: begin
        if (!stat_i.slope) state_d = ST_OFF;
        else if (stat_i.last_mul) state_d = ST_DIV;
      end
      ST_DIV:  if (stat_i.last_div) state_d = ST_OFF;
      ST_OFF:  state_d = ST_FIN;
      ST_FIN:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands for the current state.
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = RD_ZERO;
    case (state_q)
      ST_IDLE: cmd_o.cap = start;
      ST_PRE:  cmd_o.pre = 1'b1;
      ST_CHK: begin
        if (stat_i.ge_epoch || stat_i.n_zero) begin
          cmd_o.raw = 1'b1;
        end else if (stat_i.bridge) begin
          cmd_o.bridge = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_ZERO;
        end
      end
      ST_FP:   cmd_o.fp = stat_i.fp;
      ST_GRD: begin
        cmd_o.raw     = stat_i.guard;
        cmd_o.bs_init = !stat_i.guard;
      end
      ST_BS: begin
        cmd_o.rd_en  = stat_i.bs_more;
        cmd_o.rd_sel = RD_MID;
      end
      ST_BSW:  cmd_o.bs_step = 1'b1;
      ST_EXR: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LO;
      end
      ST_EXW: begin
        cmd_o.exact = stat_i.exact;
        cmd_o.pick  = !stat_i.exact;
      end
      ST_RDP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_P;
      end
      ST_RDQ: begin
        cmd_o.p_cap  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_Q;
      end
      ST_QW:   cmd_o.q_cap = 1'b1;
      ST_DIFF: cmd_o.diff = 1'b1;
      ST_MUL:  cmd_o.mul = stat_i.slope;
      ST_DIV:  cmd_o.div = 1'b1;
      ST_OFF:  cmd_o.off = 1'b1;
      ST_FIN:  cmd_o.fin = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // A query leaves idle only on a start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !start) |=> state_q == ST_IDLE)
    else $error("left idle without start");
  // Every finish returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN |=> state_q == ST_IDLE)
    else $error("finish did not return to idle");
  // Multiply only with a slope.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |-> stat_i.slope)
    else $error("multiply without slope");

endmodule

@@ src/spti_dp.sv @@
// Datapath of the sync-point time interpolator: registers, checks and the serial multiply-divide.
module spti_dp #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spti_pkg::cmd_t                cmd_i,
  output spti_pkg::stat_t               stat_o,
  input  logic                          func_i,
  input  logic [43:0]                   time_ms_i,
  input  logic [43:0]                   week_time_ms_i,
  input  logic [31:0]                   source_id_i,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [44:0]                   cfg_data_i,
  output logic                          ram_we_o,
  output logic [$clog2(MAX_POINTS)-1:0] ram_waddr_o,
  output logic [87:0]                   ram_wdata_o,
  output logic [$clog2(MAX_POINTS)-1:0] ram_raddr_o,
  input  logic [87:0]                   ram_rdata_i,
  output logic                          done_o,
  output logic [43:0]                   resolved_ms_o,
  output logic [2:0]                    confidence_o,
  output logic [31:0]                   result_id_o
);
  import spti_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

  // Configuration registers.
  logic [11:0]        anchor_q;
  logic [43:0]        fws_q, fwe_q, fpu_q;
  logic signed [44:0] uoff_q;
  logic               uov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= '0;
      fws_q    <= '0;
      fwe_q    <= '0;
      uoff_q   <= '0;
      uov_q    <= 1'b0;
      fpu_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ANCHOR_WEEK:  anchor_q <= cfg_data_i[11:0];
        CFG_WIN_START:    fws_q    <= cfg_data_i[43:0];
        CFG_WIN_END:      fwe_q    <= cfg_data_i[43:0];
        CFG_UP_OFFSET:    uoff_q   <= cfg_data_i;
        CFG_UP_OFF_VALID: uov_q    <= cfg_data_i[0];
        CFG_FIRST_UP:     fpu_q    <= cfg_data_i[43:0];
        default: ;
      endcase
    end
  end

  // Point count and store writes.
  logic [CW-1:0] count_q;
  logic          full;

  assign full        = (count_q == MAXC);
  assign ram_we_o    = cmd_i.cap && func_i == FUNC_LOAD && !full;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = {time_ms_i, week_time_ms_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ram_we_o) begin
      count_q <= count_q + CW'(1);
    end
  end

  logic [43:0] rd_host, rd_week;
  assign rd_host = ram_rdata_i[87:44];
  assign rd_week = ram_rdata_i[43:0];

  // Query registers.
  logic [43:0]        t_q;
  logic [31:0]        id_q;
  logic signed [46:0] br_q, wlo_q, whi_q, st;
  logic [42:0]        aoff_q;
  logic [CW-1:0]      lo_q, hi_q, mid_q, mid, p_idx_q, q_idx_q;
  logic               base_q_q, use_q;
  logic [2:0]         pconf_q;
  logic [43:0]        ph_q, pw_q, qh_q, qw_q, bw_q;
  logic signed [45:0] dt_q;
  logic               neg_q, slope_q;
  logic [87:0]        mcand_q, prod_q;
  logic [43:0]        mplier_q, den_q;
  logic [44:0]        rem_q;
  logic [46:0]        quot_q;
  logic               ovf_q;
  logic [6:0]         cnt_q;
  logic [43:0]        tow_q;
  logic               conv_q;
  logic [2:0]         conf_q;

  assign st  = $signed({3'b000, t_q});
  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_ZERO: ram_raddr_o = '0;
      RD_MID:  ram_raddr_o = mid[AW-1:0];
      RD_LO:   ram_raddr_o = lo_q[AW-1:0];
      RD_P:    ram_raddr_o = p_idx_q[AW-1:0];
      RD_Q:    ram_raddr_o = q_idx_q[AW-1:0];
      default: ram_raddr_o = '0;
    endcase
  end

  // Early checks.
  logic               in_win, br_in_win;
  logic signed [47:0] fp_br;
  assign in_win    = (st >= wlo_q) && (st <= whi_q);
  assign br_in_win = (br_q >= wlo_q) && (br_q <= whi_q);
  assign fp_br     = $signed({4'b0, t_q}) + $signed({4'b0, rd_week})
                   - $signed({4'b0, fpu_q});

  assign stat_o.ge_epoch = (t_q >= EPOCH_MS);
  assign stat_o.n_zero   = (count_q == '0);
  assign stat_o.bridge   = uov_q && anchor_q != '0 && fwe_q >= fws_q && !in_win
                           && br_in_win;
  assign stat_o.fp       = fpu_q != '0 && t_q < (rd_week >> 1);
  assign stat_o.guard    = anchor_q != '0 && fws_q > GUARD_MS
                           && ({1'b0, t_q} + {1'b0, GUARD_MS}) < {1'b0, fws_q};
  assign stat_o.bs_more  = lo_q < hi_q;
  assign stat_o.exact    = lo_q < count_q && rd_host == t_q;
  assign stat_o.slope    = slope_q;
  assign stat_o.last_mul = cnt_q == 7'd43;
  assign stat_o.last_div = cnt_q == 7'd87;

  // Difference terms for the slope pair.
  logic [43:0]        bh;
  logic signed [45:0] dt;
  logic signed [44:0] dh, dw;
  logic [44:0]        adt, adh, adw;
  assign bh  = base_q_q ? qh_q : ph_q;
  assign dt  = $signed({2'b00, t_q}) - $signed({2'b00, bh});
  assign dh  = $signed({1'b0, qh_q}) - $signed({1'b0, ph_q});
  assign dw  = $signed({1'b0, qw_q}) - $signed({1'b0, pw_q});
  assign adt = dt[45] ? 45'(-dt) : dt[44:0];
  assign adh = dh[44] ? 45'(-dh) : 45'(dh);
  assign adw = dw[44] ? 45'(-dw) : 45'(dw);

  // Division step and final offset.
  logic [45:0]        rem_sh;
  logic               ge;
  logic [46:0]        m;
  logic signed [47:0] off, sum;
  assign rem_sh = {rem_q, prod_q[87]};
  assign ge     = rem_sh >= {2'b00, den_q};
  assign m      = (ovf_q || quot_q > QCAP) ? QCAP : quot_q;
  assign off    = slope_q ? (neg_q ? -$signed({1'b0, m}) : $signed({1'b0, m}))
                          : 48'(dt_q);
  assign sum    = $signed({4'b0, bw_q}) + off;

  // Query sequencing registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      t_q  <= time_ms_i;
      id_q <= source_id_i;
    end
    if (cmd_i.pre) begin
      br_q   <= st + 47'(uoff_q);
      wlo_q  <= $signed({3'b000, fws_q}) - $signed({3'b000, GUARD_MS});
      whi_q  <= $signed({3'b000, fwe_q}) + $signed({3'b000, GUARD_MS});
      aoff_q <= 43'(anchor_q * WEEK_MS) + 43'(EPOCH_MS);
    end
    if (cmd_i.raw) begin
      tow_q  <= t_q;
      conv_q <= 1'b0;
      conf_q <= stat_o.ge_epoch ? CONF_EXACT : CONF_SESSION;
    end
    if (cmd_i.bridge) begin
      tow_q  <= clamp_tow(48'(br_q));
      conv_q <= 1'b1;
      conf_q <= (br_q < $signed({3'b000, fws_q})) ? CONF_BACKWARD : CONF_INTERP;
    end
    if (cmd_i.fp) begin
      tow_q  <= clamp_tow(fp_br);
      conv_q <= 1'b1;
      conf_q <= CONF_BACKWARD;
    end
    if (cmd_i.bs_init) begin
      lo_q <= '0;
      hi_q <= count_q;
    end
    if (cmd_i.rd_en && cmd_i.rd_sel == RD_MID) begin
      mid_q <= mid;
    end
    if (cmd_i.bs_step) begin
      if (rd_host < t_q) lo_q <= mid_q + CW'(1);
      else hi_q <= mid_q;
    end
    if (cmd_i.exact) begin
      tow_q  <= rd_week;
      conv_q <= 1'b1;
      conf_q <= CONF_EXACT;
    end
    if (cmd_i.pick) begin
      if (lo_q == '0) begin
        p_idx_q  <= '0;
        q_idx_q  <= CW'(1);
        base_q_q <= 1'b0;
        use_q    <= count_q >= CW'(2);
        pconf_q  <= CONF_BACKWARD;
      end else if (lo_q == count_q) begin
        p_idx_q  <= (count_q >= CW'(2)) ? count_q - CW'(2) : '0;
        q_idx_q  <= count_q - CW'(1);
        base_q_q <= 1'b1;
        use_q    <= count_q >= CW'(2);
        pconf_q  <= CONF_FORWARD;
      end else begin
        p_idx_q  <= lo_q - CW'(1);
        q_idx_q  <= lo_q;
        base_q_q <= 1'b0;
        use_q    <= 1'b1;
        pconf_q  <= CONF_INTERP;
      end
    end
    if (cmd_i.p_cap) begin
      ph_q <= rd_host;
      pw_q <= rd_week;
    end
    if (cmd_i.q_cap) begin
      qh_q <= rd_host;
      qw_q <= rd_week;
    end
    if (cmd_i.diff) begin
      bw_q     <= base_q_q ? qw_q : pw_q;
      dt_q     <= dt;
      neg_q    <= (dt[45] ^ dw[44] ^ dh[44]) && dt != '0 && dw != '0;
      slope_q  <= use_q && dh != '0;
      mcand_q  <= {43'b0, adt};
      mplier_q <= adw[43:0];
      den_q    <= adh[43:0];
      prod_q   <= '0;
      rem_q    <= '0;
      quot_q   <= '0;
      ovf_q    <= 1'b0;
      cnt_q    <= '0;
    end
    if (cmd_i.mul) begin
      if (mplier_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      cnt_q    <= stat_o.last_mul ? 7'd0 : cnt_q + 7'd1;
    end
    if (cmd_i.div) begin
      rem_q  <= ge ? 45'(rem_sh - {2'b00, den_q}) : rem_sh[44:0];
      prod_q <= prod_q << 1;
      quot_q <= {quot_q[45:0], ge};
      ovf_q  <= ovf_q | quot_q[46];
      cnt_q  <= cnt_q + 7'd1;
    end
    if (cmd_i.off) begin
      tow_q  <= clamp_tow(sum);
      conv_q <= 1'b1;
      conf_q <= pconf_q;
    end
  end

  // Epoch anchoring and the result word.
  logic [44:0] anch_sum;
  assign anch_sum = {2'b00, aoff_q} + {1'b0, tow_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (conv_q && anchor_q != '0) begin
        resolved_ms_o <= anch_sum[44] ? MASK44 : anch_sum[43:0];
      end else begin
        resolved_ms_o <= tow_q;
      end
      confidence_o <= conf_q;
      result_id_o  <= id_q;
    end
  end

  // The result strobe lasts one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
  // The store never overfills.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MAXC)
    else $error("point count beyond capacity");
  // The search bounds stay ordered and within the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.bs_step) |-> (lo_q <= hi_q && hi_q <= count_q))
    else $error("search bounds out of order");

endmodule

@@ src/sync_point_time_interpolator.sv @@
// Top level of the sync-point time interpolator.
// A load word (func 0) is written to the point store at the accepting edge;
// loads past capacity are dropped. A query word (func 1) keeps busy high
// until its result word is shown for one cycle on done_o. Pass-through and
// bridged queries, queries bridged from the first point and queries tagged
// session-only before the fix window skip the search. Others run a binary
// search over the points and, without an exact match, a projection; a sloped
// projection uses the serial 44-step multiplier and the 88-step divider.
// Results must be taken in the cycle they appear; the receiver cannot stall
// the block.
module sync_point_time_interpolator #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [43:0] time_ms_i,
  input  logic [43:0] week_time_ms_i,
  input  logic [31:0] source_id_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [44:0] cfg_data_i,
  output logic        done_o,
  output logic [43:0] resolved_ms_o,
  output logic [2:0]  confidence_o,
  output logic [31:0] result_id_o
);
  import spti_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  cmd_t          cmd;
  stat_t         stat;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [87:0]   ram_wdata, ram_rdata;

  spti_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start && !busy),
    .func_i (func_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  spti_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .time_ms_i      (time_ms_i),
    .week_time_ms_i (week_time_ms_i),
    .source_id_i    (source_id_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .done_o         (done_o),
    .resolved_ms_o  (resolved_ms_o),
    .confidence_o   (confidence_o),
    .result_id_o    (result_id_o)
  );

  // Point store: host time in the upper half, time-of-week in the lower.
  spti_ram #(.WIDTH(88), .DEPTH(MAX_POINTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the sync-point time interpolator.
module tb_top;
  import spti_pkg::*;

  localparam int  STORE_DEPTH = 1024;
  localparam int  CYCLE_LIMIT = 1500000;
  localparam int  DRAIN_CYCLES = 250;
  localparam longint unsigned M44 = 64'h0000_0FFF_FFFF_FFFF;
  localparam longint unsigned Q_CAP = 64'd1 << 46;

  typedef struct {
    logic        func;
    logic [43:0] t_ms;
    logic [43:0] w_ms;
    logic [31:0] id;
  } word_t;

  typedef struct {
    longint unsigned res;
    logic [2:0]      conf;
    logic [31:0]     id;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [43:0] time_ms_i;
  logic [43:0] week_time_ms_i;
  logic [31:0] source_id_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [44:0] cfg_data_i;
  logic        done_o;
  logic [43:0] resolved_ms_o;
  logic [2:0]  confidence_o;
  logic [31:0] result_id_o;

  // Predictor state: sync-point store and register copies.
  longint unsigned pt_host [STORE_DEPTH];
  longint unsigned pt_week [STORE_DEPTH];
  int              pt_count;
  longint unsigned r_anchor, r_win_lo, r_win_hi, r_first_up;
  longint          r_offset;
  logic            r_off_valid;

  word_t   pending_words[$];
  answer_t awaited_answers[$];
  int      mismatches;
  int      cycles;
  word_t   cur_word;
  int      gap_left;
  logic    burst_mode;

  // Planning copies of the points sent, used to aim queries.
  longint unsigned plan_host [$];
  longint unsigned h0, w0, h_next, w_next;

  sync_point_time_interpolator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .func_i(func_i), .time_ms_i(time_ms_i), .week_time_ms_i(week_time_ms_i),
    .source_id_i(source_id_i), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .done_o(done_o), .resolved_ms_o(resolved_ms_o),
    .confidence_o(confidence_o), .result_id_o(result_id_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_to_tow(longint v);
    if (v < 0) return 0;
    if (v > longint'(M44)) return longint'(M44);
    return v;
  endfunction

  function automatic longint unsigned to_unix(longint unsigned tow);
    longint unsigned r;
    r = tow;
    if (r_anchor != 0) begin
      r = r_anchor * 64'd604800000 + 64'd315964800000 + tow;
      if (r > M44) r = M44;
    end
    return r;
  endfunction

  // Exact |a|*|b|/|d| truncated, capped like the block's quotient.
  function automatic longint unsigned scale_offset(longint unsigned a, longint unsigned b,
                                                   longint unsigned d);
    logic [127:0] prod, quo;
    prod = {64'd0, a} * {64'd0, b};
    quo = prod / {64'd0, d};
    if (quo > {64'd0, Q_CAP}) return Q_CAP;
    return quo[63:0];
  endfunction

  // Base point's week time plus the query distance scaled by the slope of p, q.
  function automatic longint project_tow(int base, int p, int q, logic use_slope,
                                         longint st);
    longint dt, dh, dw, off;
    logic   neg;
    longint unsigned m;
    dt = st - longint'(pt_host[base]);
    dh = longint'(pt_host[q]) - longint'(pt_host[p]);
    dw = longint'(pt_week[q]) - longint'(pt_week[p]);
    if (!use_slope || dh == 0) begin
      off = dt;
    end else begin
      neg = ((dt < 0) != (dw < 0)) != (dh < 0);
      m = scale_offset(dt < 0 ? -dt : dt, dw < 0 ? -dw : dw, dh < 0 ? -dh : dh);
      if (dt == 0 || dw == 0) neg = 1'b0;
      off = neg ? -longint'(m) : longint'(m);
    end
    return clamp_to_tow(longint'(pt_week[base]) + off);
  endfunction

  function automatic answer_t resolve_query(longint unsigned t, logic [31:0] id);
    answer_t a;
    longint  st, wlo, whi, br;
    int      lo, hi, mid, n, b;
    a.id = id;
    st = longint'(t);
    n = pt_count;
    if (t >= 64'd315964800000) begin
      a.res = t; a.conf = CONF_EXACT; return a;
    end
    if (n == 0) begin
      a.res = t; a.conf = CONF_SESSION; return a;
    end
    // Bridge from session uptime into the fix window.
    if (r_off_valid && r_anchor != 0 && r_win_hi >= r_win_lo) begin
      wlo = longint'(r_win_lo) - 3600000;
      whi = longint'(r_win_hi) + 3600000;
      if (!(st >= wlo && st <= whi)) begin
        br = st + r_offset;
        if (br >= wlo && br <= whi) begin
          a.res = to_unix(clamp_to_tow(br));
          a.conf = (br < longint'(r_win_lo)) ? CONF_BACKWARD : CONF_INTERP;
          return a;
        end
      end
    end
    if (r_first_up > 0 && t < pt_week[0] / 2) begin
      br = st + (longint'(pt_week[0]) - longint'(r_first_up));
      a.res = to_unix(clamp_to_tow(br)); a.conf = CONF_BACKWARD; return a;
    end
    if (r_anchor != 0 && r_win_lo > 64'd3600000 && t + 64'd3600000 < r_win_lo) begin
      a.res = t; a.conf = CONF_SESSION; return a;
    end
    // Lower-bound search over the stored order.
    lo = 0; hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (pt_host[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    if (lo < n && pt_host[lo] == t) begin
      a.res = to_unix(pt_week[lo]); a.conf = CONF_EXACT;
    end else if (lo == 0) begin
      a.res = to_unix(project_tow(0, 0, 1, n >= 2, st)); a.conf = CONF_BACKWARD;
    end else if (lo == n) begin
      b = (n >= 2) ? n - 2 : 0;
      a.res = to_unix(project_tow(n - 1, b, n - 1, n >= 2, st)); a.conf = CONF_FORWARD;
    end else begin
      a.res = to_unix(project_tow(lo - 1, lo - 1, lo, 1'b1, st)); a.conf = CONF_INTERP;
    end
    return a;
  endfunction

  // Applies one accepted word to the predictor.
  task automatic absorb_word(word_t wd);
    answer_t ans;
    if (wd.func == FUNC_LOAD) begin
      if (pt_count < STORE_DEPTH) begin
        pt_host[pt_count] = 64'(wd.t_ms);
        pt_week[pt_count] = 64'(wd.w_ms);
        pt_count++;
      end
    end else begin
      ans = resolve_query(64'(wd.t_ms), wd.id);
      awaited_answers = {awaited_answers, ans};
    end
  endtask

  // Driver: presents pending words with random gaps and bursts.
  always @(posedge clk_i) begin
    logic fire;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) absorb_word(cur_word);
      if (fire || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          func_i <= cur_word.func;
          time_ms_i <= cur_word.t_ms;
          week_time_ms_i <= cur_word.w_ms;
          source_id_i <= cur_word.id;
          start <= 1'b1;
          if ($urandom_range(0, 29) == 0) burst_mode = ~burst_mode;
          gap_left = burst_mode ? 0 : $urandom_range(0, 14);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && done_o) begin
      if (awaited_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: res=%0d conf=%0d id=%h",
                   resolved_ms_o, confidence_o, result_id_o);
      end else begin
        want = awaited_answers.pop_front();
        if (64'(resolved_ms_o) !== want.res || confidence_o !== want.conf ||
            result_id_o !== want.id) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected res=%0d conf=%0d id=%h, got res=%0d conf=%0d id=%h",
                     want.res, want.conf, want.id,
                     resolved_ms_o, confidence_o, result_id_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic queue_word(logic func, longint unsigned t, longint unsigned w);
    word_t wd;
    wd.func = func;
    wd.t_ms = t[43:0];
    wd.w_ms = w[43:0];
    wd.id = $urandom;
    pending_words = {pending_words, wd};
    if (func == FUNC_LOAD) plan_host = {plan_host, t};
  endtask

  task automatic wait_quiet();
    while (pending_words.size() > 0 || start || busy || awaited_answers.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, longint v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v[44:0];
    case (idx)
      CFG_ANCHOR_WEEK:  r_anchor = v & 64'hFFF;
      CFG_WIN_START:    r_win_lo = v & M44;
      CFG_WIN_END:      r_win_hi = v & M44;
      CFG_UP_OFFSET:    r_offset = longint'({{19{v[44]}}, v[44:0]});
      CFG_UP_OFF_VALID: r_off_valid = v[0];
      CFG_FIRST_UP:     r_first_up = v & M44;
      default: ;
    endcase
  endtask

  function automatic longint unsigned rand44();
    return {$urandom, $urandom} & M44;
  endfunction

  // Picks a query time aimed at the planned points, or anywhere.
  function automatic longint unsigned aim_query();
    int k, lim;
    lim = (plan_host.size() < STORE_DEPTH) ? plan_host.size() : STORE_DEPTH;
    k = $urandom_range(0, lim - 1);
    case ($urandom_range(0, 7))
      0, 1: return plan_host[k];
      2, 3: return plan_host[k] + $urandom_range(1, 30000);
      4: return (h0 > 1) ? $urandom_range(0, 1000) + h0 / 2 : 0;
      5: return h_next + $urandom_range(0, 2000000);
      6: return rand44();
      default: return {$urandom, $urandom} % 64'd315964800000;
    endcase
  endfunction

  initial begin
    int phase, i;
    longint unsigned step, ws;
    rst_ni = 1'b0;
    start = 1'b0;
    func_i = FUNC_LOAD;
    time_ms_i = '0;
    week_time_ms_i = '0;
    source_id_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_ANCHOR_WEEK;
    cfg_data_i = '0;
    mismatches = 0;
    cycles = 0;
    gap_left = 0;
    burst_mode = 1'b0;
    pt_count = 0;
    r_anchor = 0; r_win_lo = 0; r_win_hi = 0; r_offset = 0;
    r_off_valid = 1'b0; r_first_up = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    h0 = 64'd1000000 + $urandom_range(0, 1 << 30);
    w0 = (64'd1 << 20) + {$urandom_range(0, 255), $urandom};

    // Directed: empty store, then one, two and repeated points.
    write_reg(CFG_ANCHOR_WEEK, 0);
    write_reg(CFG_WIN_START, 0);
    write_reg(CFG_WIN_END, 0);
    write_reg(CFG_UP_OFFSET, 0);
    write_reg(CFG_UP_OFF_VALID, 0);
    write_reg(CFG_FIRST_UP, 0);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    queue_word(FUNC_QUERY, 0, 0);
    queue_word(FUNC_QUERY, M44, M44);
    queue_word(FUNC_QUERY, 64'd315964800000, 0);
    queue_word(FUNC_QUERY, 64'd315964799999, 0);
    queue_word(FUNC_LOAD, h0, w0);
    queue_word(FUNC_QUERY, h0, 0);
    queue_word(FUNC_QUERY, h0 - 500, 0);
    queue_word(FUNC_QUERY, 0, 0);
    queue_word(FUNC_QUERY, h0 + 700, 0);
    queue_word(FUNC_LOAD, h0 + 1000, w0 + 1000);
    queue_word(FUNC_QUERY, h0 + 300, 0);
    queue_word(FUNC_QUERY, h0 - 100000, 0);
    queue_word(FUNC_QUERY, h0 + 5000, 0);
    // Repeated host time: the forward slope pair has equal host times.
    queue_word(FUNC_LOAD, h0 + 1000, w0 + 5000);
    queue_word(FUNC_QUERY, h0 + 9000, 0);
    // A steep step pushes forward projections to saturation.
    queue_word(FUNC_LOAD, h0 + 1001, M44 - 5);
    queue_word(FUNC_QUERY, h0 + 400000, 0);
    queue_word(FUNC_QUERY, h0 + 1000, 0);
    queue_word(FUNC_QUERY, 0, 0);
    wait_quiet();

    h_next = h0 + 2000;
    w_next = w0 + 2000;
    for (phase = 1; phase <= 7; phase++) begin
      // New register setting, block idle.
      write_reg(CFG_ANCHOR_WEEK, phase == 1 ? 4095 : phase == 2 ? 0 : $urandom_range(1, 4095));
      ws = (phase == 3) ? 0 : (phase == 4) ? M44 : w0 - $urandom_range(0, 1 << 20);
      write_reg(CFG_WIN_START, ws);
      write_reg(CFG_WIN_END, phase == 4 ? M44 : phase == 5 ? ws / 2
                : ws + $urandom_range(0, 1 << 30));
      write_reg(CFG_UP_OFFSET, phase == 1 ? -(longint'(1) << 44) :
                phase == 2 ? (longint'(1) << 44) - 1 :
                longint'(w0) - longint'(h0) + $urandom_range(0, 4000) - 2000);
      write_reg(CFG_UP_OFF_VALID, (phase % 2 == 1) ? 1 : $urandom_range(0, 1));
      write_reg(CFG_FIRST_UP, phase == 2 ? M44 : phase == 3 ? 0 : h0 + $urandom_range(0, 5000));
      @(posedge clk_i);
      cfg_we_i <= 1'b0;

      for (i = 0; i < 225; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          if (plan_host.size() >= STORE_DEPTH + 10) begin
            // Store is full: these loads are dropped.
            queue_word(FUNC_LOAD, rand44(), rand44());
          end else if ($urandom_range(0, 49) == 0) begin
            // Occasional out-of-order or repeated point.
            queue_word(FUNC_LOAD, h_next - $urandom_range(0, 3000), rand44());
          end else begin
            step = $urandom_range(1, 50000);
            h_next += step;
            w_next = w_next + step + $urandom_range(0, 400) - 200;
            queue_word(FUNC_LOAD, h_next, w_next);
          end
        end else begin
          queue_word(FUNC_QUERY, aim_query(), rand44());
        end
      end
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/spti_pkg.sv
src/spti_ram.sv
src/spti_ctrl.sv
src/spti_dp.sv
src/sync_point_time_interpolator.sv
tb/sv/tb_top.sv
